@@ sv/aabb_pair_collision_resolve_defines.svh @@
// ----------------------------------------------------------------------------
// aabb_pair_collision_resolve_defines
// assertion macros used by the checker file of the collision block
// ----------------------------------------------------------------------------
`ifndef AABB_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`define AABB_PAIR_COLLISION_RESOLVE_DEFINES_SVH

// clocked assertion, off while reset is held
`define APCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds while reset is held
`define APCR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/apcr_pkg.sv @@
// ----------------------------------------------------------------------------
// apcr_pkg
// shared widths, types and codes of the box pair collision block
// ----------------------------------------------------------------------------
package apcr_pkg;

    // one signed fixed-point coordinate, x y z packed into a triple
    localparam int COORD_WIDTH = 16;
    localparam int NUM_AXES    = 3;
    localparam int SEL_W       = $clog2(NUM_AXES);
    localparam int TRIPLE_W    = NUM_AXES * COORD_WIDTH;

    // stream widths
    localparam int IN_DATA_W   = 6 * TRIPLE_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_DATA_W  = 2 * TRIPLE_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [TRIPLE_W-1:0] triple_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } push_axis_t;

    // per-axis overlap status
    typedef struct packed {
        logic   hit;
        coord_t ov;
        logic   delta_pos;
    } axis_t;

    // resolved result of one box pair
    typedef struct packed {
        logic       hit;
        push_axis_t push_axis;
        triple_t    shift_a;
        triple_t    shift_b;
    } res_t;

endpackage

@@ sv/apcr_axis.sv @@
// ----------------------------------------------------------------------------
// apcr_axis
// overlap test, saturated overlap and position sign on one axis
// ----------------------------------------------------------------------------
module apcr_axis
(
    input  apcr_pkg::coord_t amin,
    input  apcr_pkg::coord_t amax,
    input  apcr_pkg::coord_t bmin,
    input  apcr_pkg::coord_t bmax,
    input  apcr_pkg::coord_t pa,
    input  apcr_pkg::coord_t pb,
    output apcr_pkg::axis_t  result
);

    localparam int CW = apcr_pkg::COORD_WIDTH;

    logic signed [CW:0] d1;
    logic signed [CW:0] d2;
    logic signed [CW:0] dmin;
    logic signed [CW:0] delta;

    always_comb
    begin
        d1    = {amax[CW-1], amax} - {bmin[CW-1], bmin};
        d2    = {bmax[CW-1], bmax} - {amin[CW-1], amin};
        dmin  = (d1 < d2) ? d1 : d2;
        delta = {pb[CW-1], pb} - {pa[CW-1], pa};

        result.hit       = (amin <= bmax) && (amax >= bmin);
        result.delta_pos = !delta[CW] && (delta != '0);

        // clamp to the signed coordinate range
        if (!dmin[CW] && dmin[CW-1])
        begin
            result.ov = {1'b0, {(CW-1){1'b1}}};
        end
        else if (dmin[CW] && !dmin[CW-1])
        begin
            result.ov = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            result.ov = dmin[CW-1:0];
        end
    end

endmodule

@@ sv/apcr_resolve.sv @@
// ----------------------------------------------------------------------------
// apcr_resolve
// least-overlap axis choice and split of the push between the two bodies
// ----------------------------------------------------------------------------
module apcr_resolve
(
    input  apcr_pkg::axis_t [apcr_pkg::NUM_AXES-1:0] ax,
    input  logic                                     a_fixed,
    input  logic                                     b_fixed,
    output apcr_pkg::res_t                           res
);

    localparam int CW = apcr_pkg::COORD_WIDTH;

    logic [apcr_pkg::SEL_W-1:0] sel;
    logic                       hit_all;
    logic                       push_en;
    apcr_pkg::coord_t           least;
    apcr_pkg::coord_t           push;
    apcr_pkg::coord_t           neg;
    apcr_pkg::coord_t           sa;
    apcr_pkg::coord_t           sb;

    always_comb
    begin
        // first minimum wins, x before y before z
        sel = apcr_pkg::SEL_W'(0);
        if (!(ax[0].ov <= ax[1].ov && ax[0].ov <= ax[2].ov))
        begin
            sel = (ax[1].ov <= ax[2].ov) ? apcr_pkg::SEL_W'(1) : apcr_pkg::SEL_W'(2);
        end

        hit_all = ax[0].hit && ax[1].hit && ax[2].hit;
        least   = ax[sel].ov;
        push_en = hit_all && (least > 0);
        push    = ax[sel].delta_pos ? least : -least;
        neg     = -push;

        case ({a_fixed, b_fixed})
            2'b10:
            begin
                sa = '0;
                sb = push;
            end
            2'b01:
            begin
                sa = neg;
                sb = '0;
            end
            2'b00:
            begin
                sa = neg >>> 1;
                sb = push >>> 1;
            end
            default:
            begin
                sa = '0;
                sb = '0;
            end
        endcase

        res.hit       = hit_all;
        res.push_axis = push_en ? apcr_pkg::push_axis_t'(sel + apcr_pkg::SEL_W'(1))
                                : apcr_pkg::AXIS_NONE;
        for (int k = 0; k < apcr_pkg::NUM_AXES; k++)
        begin
            res.shift_a[k*CW +: CW] = (push_en && sel == apcr_pkg::SEL_W'(k)) ? sa : '0;
            res.shift_b[k*CW +: CW] = (push_en && sel == apcr_pkg::SEL_W'(k)) ? sb : '0;
        end
    end

endmodule

@@ sv/aabb_pair_collision_resolve.sv @@
// ----------------------------------------------------------------------------
// aabb_pair_collision_resolve
// overlap test and minimum-axis separation of two 3d axis-aligned boxes
// ----------------------------------------------------------------------------
// One box pair per transaction, one transaction per clock cycle sustained while
// m_tready stays high. A pair accepted on s_* is captured in an input register
// at the accepting edge, resolved by the per-axis units and the resolve logic in
// a single pass, and loaded into the result register on m_* once that register
// is free or being drained, which raises m_tvalid. The result register parts the
// two sides, so a new pair is taken while a finished result still waits; s_tready
// drops only when both the input and the result register are full and m_tready
// is low. Coordinates are signed Q8.8 by default, x in the lowest lane of each
// triple. Overlaps saturate to the coordinate range; the push goes to the movable
// body, halved with an arithmetic shift when both move, and is dropped when both
// are static.
// ----------------------------------------------------------------------------
module aabb_pair_collision_resolve
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // box_a_min, box_a_max, box_b_min, box_b_max, pos_a, pos_b
    input  logic [apcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // a_fixed, b_fixed
    input  logic [apcr_pkg::IN_TUSER_W-1:0]  s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // shift_a, shift_b
    output logic [apcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit, push_axis
    output logic [apcr_pkg::OUT_TUSER_W-1:0] m_tuser
);

    localparam int CW = apcr_pkg::COORD_WIDTH;
    localparam int TW = apcr_pkg::TRIPLE_W;

    // input register
    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [apcr_pkg::IN_DATA_W-1:0]  in_data_reg;
    logic [apcr_pkg::IN_TUSER_W-1:0] in_user_reg;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    apcr_pkg::res_t                  out_res_reg;

    // stage control
    logic                            advance;
    logic                            in_load;
    logic                            out_load;

    apcr_pkg::axis_t [apcr_pkg::NUM_AXES-1:0] ax;
    apcr_pkg::res_t                           res;

    // the result register moves on when it is empty or being drained
    always_comb
    begin
        advance        = !out_valid_reg || m_tready;
        s_tready       = !in_valid_reg || advance;
        in_load        = s_tvalid && s_tready;
        out_load       = advance && in_valid_reg;
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_tdata[apcr_pkg::IN_DATA_W-1:0];
            in_user_reg <= s_tuser;
        end
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    // one overlap unit per axis, lanes sliced out of the packed triples
    for (genvar k = 0; k < apcr_pkg::NUM_AXES; k++)
    begin : g_axis
        apcr_axis u_axis
        (
            .amin   (in_data_reg[0*TW + k*CW +: CW]),
            .amax   (in_data_reg[1*TW + k*CW +: CW]),
            .bmin   (in_data_reg[2*TW + k*CW +: CW]),
            .bmax   (in_data_reg[3*TW + k*CW +: CW]),
            .pa     (in_data_reg[4*TW + k*CW +: CW]),
            .pb     (in_data_reg[5*TW + k*CW +: CW]),
            .result (ax[k])
        );
    end

    apcr_resolve u_resolve
    (
        .ax      (ax),
        .a_fixed (in_user_reg[0]),
        .b_fixed (in_user_reg[1]),
        .res     (res)
    );

    // outputs straight from the result register
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = apcr_pkg::OUT_TDATA_W'({out_res_reg.shift_b, out_res_reg.shift_a});
    assign m_tuser  = {out_res_reg.push_axis, out_res_reg.hit};

endmodule

@@ sv/apcr_checker.sv @@
// ----------------------------------------------------------------------------
// apcr_checker
// port-level checks of the box pair collision block, bound to the top level
// ----------------------------------------------------------------------------
`include "aabb_pair_collision_resolve_defines.svh"

module apcr_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [apcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [apcr_pkg::OUT_TUSER_W-1:0] m_tuser
);

    // a stalled result keeps its valid and its payload
    `APCR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // a free result side never blocks the input side
    `APCR_ASSERT_ALWAYS(a_no_bubble, (!m_tvalid || m_tready) |-> s_tready, "input stalled while result side free")

    // no overlap means no push axis
    `APCR_ASSERT(a_miss_no_axis, m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0, "push axis set without hit")

    // no push axis means both shifts are zero
    `APCR_ASSERT(a_none_zero, m_tvalid && m_tuser[2:1] == 2'd0 |-> m_tdata == '0, "nonzero shift without push axis")

endmodule

bind aabb_pair_collision_resolve apcr_checker u_checker (.*);

@@ sim/aabb_pair_collision_check.sv @@
// ----------------------------------------------------------------------------
// aabb_pair_collision_check
// watches both streams of the box pair block, predicts each resolution and
// compares it field by field with what the block hands out
// ----------------------------------------------------------------------------
module aabb_pair_collision_check
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [apcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [apcr_pkg::IN_TUSER_W-1:0]  s_tuser,

    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [apcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [apcr_pkg::OUT_TUSER_W-1:0] m_tuser,

    output int                               resolutions_open,
    output int                               mismatch_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = apcr_pkg::COORD_WIDTH;
    localparam int NA        = apcr_pkg::NUM_AXES;
    localparam int TW        = apcr_pkg::TRIPLE_W;
    localparam int COORD_MAX = 2 ** (CW - 1) - 1;
    localparam int COORD_MIN = -(2 ** (CW - 1));

    apcr_pkg::res_t resolutions_due[$];

    // exact integer overlap test and least-axis push of one box pair
    function automatic apcr_pkg::res_t resolve_pair(
        input apcr_pkg::triple_t a_lo, input apcr_pkg::triple_t a_hi,
        input apcr_pkg::triple_t b_lo, input apcr_pkg::triple_t b_hi,
        input apcr_pkg::triple_t p_a, input apcr_pkg::triple_t p_b,
        input logic a_static, input logic b_static);
        apcr_pkg::res_t r;
        int   lo_a;
        int   hi_a;
        int   lo_b;
        int   hi_b;
        int   d1;
        int   d2;
        int   ov[NA];
        int   least;
        int   push;
        int   sa;
        int   sb;
        int   sel;
        logic touch;

        r     = '0;
        touch = 1'b1;
        sel   = -1;
        for (int k = 0; k < NA; k++)
        begin
            lo_a = $signed(a_lo[k*CW +: CW]);
            hi_a = $signed(a_hi[k*CW +: CW]);
            lo_b = $signed(b_lo[k*CW +: CW]);
            hi_b = $signed(b_hi[k*CW +: CW]);
            if (!(lo_a <= hi_b && hi_a >= lo_b))
                touch = 1'b0;
            d1    = hi_a - lo_b;
            d2    = hi_b - lo_a;
            ov[k] = (d1 < d2) ? d1 : d2;
            if (ov[k] > COORD_MAX)
                ov[k] = COORD_MAX;
            if (ov[k] < COORD_MIN)
                ov[k] = COORD_MIN;
        end
        r.hit       = touch;
        r.push_axis = apcr_pkg::AXIS_NONE;
        if (!touch)
            return r;

        least = ov[0];
        for (int k = 1; k < NA; k++)
            if (ov[k] < least)
                least = ov[k];
        // first axis in x y z order, zero overlap gives no push
        for (int k = 0; k < NA; k++)
            if (sel < 0 && ov[k] == least && ov[k] > 0)
                sel = k;
        if (sel < 0)
            return r;

        lo_a = $signed(p_a[sel*CW +: CW]);
        lo_b = $signed(p_b[sel*CW +: CW]);
        push = (lo_b - lo_a > 0) ? ov[sel] : -ov[sel];
        sa   = 0;
        sb   = 0;
        if (a_static && !b_static)
            sb = push;
        else if (!a_static && b_static)
            sa = -push;
        else if (!a_static && !b_static)
        begin
            sa = (-push) >>> 1;
            sb = push >>> 1;
        end

        case (sel)
            0:       r.push_axis = apcr_pkg::AXIS_X;
            1:       r.push_axis = apcr_pkg::AXIS_Y;
            default: r.push_axis = apcr_pkg::AXIS_Z;
        endcase
        r.shift_a[sel*CW +: CW] = apcr_pkg::coord_t'(sa);
        r.shift_b[sel*CW +: CW] = apcr_pkg::coord_t'(sb);
        return r;
    endfunction

    initial
    begin
        resolutions_open = 0;
        mismatch_count   = 0;
    end

    always @(posedge clk)
    begin
        apcr_pkg::res_t want;
        apcr_pkg::res_t got;

        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                resolutions_due.push_back(resolve_pair(
                    s_tdata[0*TW +: TW], s_tdata[1*TW +: TW],
                    s_tdata[2*TW +: TW], s_tdata[3*TW +: TW],
                    s_tdata[4*TW +: TW], s_tdata[5*TW +: TW],
                    s_tuser[0], s_tuser[1]));

            if (m_tvalid && m_tready)
            begin
                got.hit       = m_tuser[0];
                got.push_axis = apcr_pkg::push_axis_t'(m_tuser[2:1]);
                got.shift_a   = m_tdata[0 +: TW];
                got.shift_b   = m_tdata[TW +: TW];
                if (resolutions_due.size() == 0)
                begin
                    $display("%0t: unexpected result hit %0b axis %0d a %h b %h", $time,
                             got.hit, got.push_axis, got.shift_a, got.shift_b);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = resolutions_due.pop_front();
                    if (got.hit !== want.hit || got.push_axis !== want.push_axis ||
                        got.shift_a !== want.shift_a || got.shift_b !== want.shift_b)
                    begin
                        $display("%0t: hit exp %0b got %0b, axis exp %0d got %0d", $time,
                                 want.hit, got.hit, want.push_axis, got.push_axis);
                        $display("%0t: shift_a exp %h got %h, shift_b exp %h got %h", $time,
                                 want.shift_a, got.shift_a, want.shift_b, got.shift_b);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            resolutions_open <= resolutions_due.size();
        end
    end

endmodule

@@ sim/tb_aabb_pair_collision_resolve.sv @@
// ----------------------------------------------------------------------------
// tb_aabb_pair_collision_resolve
// drives box pairs into the collision block under random idling on both
// streams and reports the verdict of the attached result checker
// ----------------------------------------------------------------------------
module tb_aabb_pair_collision_resolve;

    timeunit 1ns;
    timeprecision 1ps;

    // q8.8 unit step
    localparam int ONE         = 256;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 16;
    localparam int CW          = apcr_pkg::COORD_WIDTH;
    localparam int NA          = apcr_pkg::NUM_AXES;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [apcr_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [apcr_pkg::IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [apcr_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [apcr_pkg::OUT_TUSER_W-1:0] m_tuser;

    int resolutions_open;
    int mismatch_count;
    int cycle_count = 0;

    // percent of cycles in which each side holds back
    int feed_idle  = 21;
    int drain_idle = 66;

    initial
    begin
        forever #6 clk = ~clk;
    end

    aabb_pair_collision_resolve u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    aabb_pair_collision_check u_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .resolutions_open (resolutions_open),
        .mismatch_count   (mismatch_count)
    );

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= drain_idle);

    // hard stop in case the block hangs or drops a result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL aabb_pair_collision_resolve");
            $finish;
        end
    end

    // coordinate range ends
    function automatic int COORD_MAX_V();
        return 2 ** (CW - 1) - 1;
    endfunction

    function automatic int COORD_MIN_V();
        return -(2 ** (CW - 1));
    endfunction

    // pack three signed coordinates, x in the lowest lane
    function automatic apcr_pkg::triple_t trip(input int x, input int y, input int z);
        return {apcr_pkg::coord_t'(z), apcr_pkg::coord_t'(y), apcr_pkg::coord_t'(x)};
    endfunction

    // one transaction on the slave side; valid stays high into the next call
    // unless that call starts with an idle cycle
    task automatic send_pair(input apcr_pkg::triple_t a_lo, input apcr_pkg::triple_t a_hi,
                             input apcr_pkg::triple_t b_lo, input apcr_pkg::triple_t b_hi,
                             input apcr_pkg::triple_t p_a, input apcr_pkg::triple_t p_b,
                             input logic a_static, input logic b_static);
        while ($urandom_range(0, 99) < feed_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p_b, p_a, b_hi, b_lo, a_hi, a_lo};
        s_tuser  <= {b_static, a_static};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // random pair: mostly overlapping boxes with random extents, some with
    // the same geometry on every axis so the overlaps tie, some placed right
    // at the touching edge, and the rest raw bit patterns (inverted and huge
    // boxes, saturating overlaps)
    task automatic send_random_pair();
        int mode;
        int lo;
        int wa;
        int wb;
        int off;
        int a_lo[NA];
        int a_hi[NA];
        int b_lo[NA];
        int b_hi[NA];
        int p_a[NA];
        int p_b[NA];
        apcr_pkg::triple_t raw[4];

        mode = $urandom_range(0, 99);
        wa   = 0;
        wb   = 0;
        off  = 0;
        for (int k = 0; k < NA; k++)
        begin
            // tie mode keeps extents and offset of the x axis
            if (k == 0 || mode < 60 || mode >= 75)
            begin
                wa = $urandom_range(0, 3000);
                wb = $urandom_range(0, 3000);
                if (mode < 75)
                    off = $urandom_range(0, wa + wb) - wb;
                else
                    off = ($urandom_range(0, 1) ? wa : -wb) + $urandom_range(0, 4) - 2;
            end
            lo      = $urandom_range(0, 65535) - 32768;
            a_lo[k] = lo;
            a_hi[k] = lo + wa;
            b_lo[k] = lo + off;
            b_hi[k] = lo + off + wb;
            p_a[k]  = $urandom_range(0, 65535) - 32768;
            // small or zero position differences half of the time
            p_b[k]  = $urandom_range(0, 1) ? p_a[k] + $urandom_range(0, 6) - 3
                                           : $urandom_range(0, 65535) - 32768;
        end
        for (int k = 0; k < 4; k++)
            raw[k] = apcr_pkg::triple_t'({$urandom, $urandom});
        if (mode >= 88)
            send_pair(raw[0], raw[1], raw[2], raw[3],
                      trip(p_a[0], p_a[1], p_a[2]), trip(p_b[0], p_b[1], p_b[2]),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
            send_pair(trip(a_lo[0], a_lo[1], a_lo[2]), trip(a_hi[0], a_hi[1], a_hi[2]),
                      trip(b_lo[0], b_lo[1], b_lo[2]), trip(b_hi[0], b_hi[1], b_hi[2]),
                      trip(p_a[0], p_a[1], p_a[2]), trip(p_b[0], p_b[1], p_b[2]),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        apcr_pkg::triple_t cube;
        apcr_pkg::triple_t origin;

        cube   = trip(4 * ONE, 4 * ONE, 4 * ONE);
        origin = trip(0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed pairs ----------------
        // degenerate boxes at the origin: touching on every axis, zero push
        send_pair(origin, origin, origin, origin, origin, origin, 1'b0, 1'b0);
        // every input bit high: single points at -1 lsb, zero push
        send_pair('1, '1, '1, '1, '1, '1, 1'b1, 1'b1);
        // apart on x only, then on z only
        send_pair(origin, cube, trip(5 * ONE, 0, 0), trip(9 * ONE, 4 * ONE, 4 * ONE),
                  origin, cube, 1'b0, 1'b0);
        send_pair(origin, cube, trip(0, 0, 4 * ONE + 1), trip(4 * ONE, 4 * ONE, 6 * ONE),
                  origin, cube, 1'b0, 1'b0);
        // x least, b ahead, both move
        send_pair(origin, cube, trip(3 * ONE, ONE, 0), trip(7 * ONE, 5 * ONE, 4 * ONE),
                  origin, trip(ONE, 0, 0), 1'b0, 1'b0);
        // y least, b behind, only b moves
        send_pair(origin, cube, trip(ONE, 3 * ONE, 0), trip(5 * ONE, 7 * ONE, 4 * ONE),
                  trip(0, ONE, 0), origin, 1'b1, 1'b0);
        // z least, equal positions give a negative push, only a moves
        send_pair(origin, cube, trip(ONE, 0, 3 * ONE + 7), trip(5 * ONE, 4 * ONE, 7 * ONE),
                  cube, cube, 1'b0, 1'b1);
        // same geometry with both static: axis named, no shift
        send_pair(origin, cube, trip(ONE, 0, 3 * ONE + 7), trip(5 * ONE, 4 * ONE, 7 * ONE),
                  origin, cube, 1'b1, 1'b1);
        // x and y tie, x wins
        send_pair(origin, cube, trip(2 * ONE, 2 * ONE, ONE), trip(6 * ONE, 6 * ONE, 5 * ONE),
                  cube, origin, 1'b0, 1'b0);
        // y and z tie with x larger, y wins
        send_pair(origin, cube, trip(ONE, 3 * ONE, 3 * ONE), trip(5 * ONE, 7 * ONE, 7 * ONE),
                  origin, cube, 1'b1, 1'b0);
        // full-range boxes: every overlap saturates, odd push halved
        send_pair(trip(COORD_MIN_V(), COORD_MIN_V(), COORD_MIN_V()),
                  trip(COORD_MAX_V(), COORD_MAX_V(), COORD_MAX_V()),
                  trip(COORD_MIN_V(), COORD_MIN_V(), COORD_MIN_V()),
                  trip(COORD_MAX_V(), COORD_MAX_V(), COORD_MAX_V()),
                  origin, trip(1, 1, 1), 1'b0, 1'b0);
        // x overlap of 257 lsb, push toward minus with an odd value and both moving
        send_pair(origin, cube, trip(4 * ONE - 257, 0, 0), trip(8 * ONE, 4 * ONE, 4 * ONE),
                  trip(1, 0, 0), origin, 1'b0, 1'b0);
        // inverted box a, touching at the edges: zero push
        send_pair(trip(4 * ONE, 0, 0), trip(0, 4 * ONE, 4 * ONE), origin, cube,
                  origin, cube, 1'b0, 1'b0);
        // inverted box a with a positive overlap
        send_pair(trip(2 * ONE, 0, 0), trip(ONE, 4 * ONE, 4 * ONE), origin, cube,
                  origin, cube, 1'b0, 1'b1);
        // position extremes: a at the top, b at the bottom of the range
        send_pair(origin, cube, trip(3 * ONE, 0, 0), trip(7 * ONE, 4 * ONE, 4 * ONE),
                  trip(COORD_MAX_V(), COORD_MAX_V(), COORD_MAX_V()),
                  trip(COORD_MIN_V(), COORD_MIN_V(), COORD_MIN_V()), 1'b0, 1'b0);
        // and the other way round, difference wider than a coordinate
        send_pair(origin, cube, trip(3 * ONE, 0, 0), trip(7 * ONE, 4 * ONE, 4 * ONE),
                  trip(COORD_MIN_V(), COORD_MIN_V(), COORD_MIN_V()),
                  trip(COORD_MAX_V(), COORD_MAX_V(), COORD_MAX_V()), 1'b1, 1'b0);

        // hold off until the block has drained everything
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (resolutions_open != 0)
            @(posedge clk);

        // ---------------- random pairs, three idling phases ----------------
        repeat (395) send_random_pair();
        feed_idle  = 66;
        drain_idle = 21;
        repeat (400) send_random_pair();
        feed_idle  = 0;
        drain_idle = 0;
        repeat (400) send_random_pair();

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (resolutions_open != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS aabb_pair_collision_resolve");
        else
            $display("FAIL aabb_pair_collision_resolve");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/apcr_pkg.sv
sv/apcr_axis.sv
sv/apcr_resolve.sv
sv/aabb_pair_collision_resolve.sv
sv/apcr_checker.sv
sim/aabb_pair_collision_check.sv
sim/tb_aabb_pair_collision_resolve.sv
